>>> src/tnd_pkg.sv
package tnd_pkg;

  // decode modes; code 3 is unused and decodes as control
  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_PACK = 2'd2
  } mode_t;

  // register indexes on the config port
  localparam logic [1:0] REG_LITERAL_KEY   = 2'd0;
  localparam logic [1:0] REG_LINE_END_CODE = 2'd1;

  localparam logic [7:0] KEY_RESET      = 8'h33;
  localparam logic [7:0] LINE_END_RESET = 8'h0D;
  localparam logic [7:0] CTRL_LINE_END  = 8'hFF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // words produced by one decoded byte
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } res_t;

  function automatic logic [7:0] char_lut(input logic [3:0] code);
    logic [7:0] c;
    case (code)
      4'h0:    c = 8'h00;
      4'h1:    c = 8'h20;
      4'h2:    c = 8'h2D;
      4'h3:    c = 8'h2E;
      4'h4:    c = 8'h30;
      4'h5:    c = 8'h31;
      4'h6:    c = 8'h32;
      4'h7:    c = 8'h33;
      4'h8:    c = 8'h34;
      4'h9:    c = 8'h35;
      4'hA:    c = 8'h36;
      4'hB:    c = 8'h37;
      4'hC:    c = 8'h38;
      4'hD:    c = 8'h39;
      4'hE:    c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> src/tnd_decode.sv
module tnd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          item_adv,
  input  logic [7:0]    item_byte,
  input  logic          item_fend,
  output tnd_pkg::res_t res
);
  import tnd_pkg::*;

  logic [7:0] key_r, line_end_r;
  mode_t      mode_r, mode_nxt;
  logic [6:0] chars_left_r, chars_left_nxt;
  logic [7:0] hi_c, lo_c;

  assign hi_c = char_lut(item_byte[7:4]);
  assign lo_c = char_lut(item_byte[3:0]);

  always_comb begin
    res            = '0;
    mode_nxt       = mode_r;
    chars_left_nxt = chars_left_r;
    case (mode_r)
      MODE_LIT: begin
        res.cnt        = 2'd1;
        res.byte0      = item_byte ^ key_r;
        chars_left_nxt = (chars_left_r != 7'd0) ? chars_left_r - 7'd1 : 7'd0;
      end
      MODE_PACK: begin
        res.cnt   = 2'd1;
        res.byte0 = hi_c;
        if (chars_left_r >= 7'd2 && lo_c != 8'h00) begin
          res.cnt        = 2'd2;
          res.byte1      = lo_c;
          chars_left_nxt = chars_left_r - 7'd2;
        end else begin
          chars_left_nxt = 7'd0;
        end
      end
      default: begin
        if (item_byte == CTRL_LINE_END) begin
          res.cnt        = 2'd1;
          res.byte0      = line_end_r;
          chars_left_nxt = 7'd0;
        end else begin
          chars_left_nxt = item_byte[6:0];
        end
      end
    endcase
    // run direction only set from a control byte; otherwise keep mode
    if (chars_left_nxt == 7'd0) begin
      mode_nxt = MODE_CTRL;
    end else if (mode_r != MODE_LIT && mode_r != MODE_PACK) begin
      mode_nxt = item_byte[7] ? MODE_PACK : MODE_LIT;
    end
    if (item_fend) begin
      mode_nxt       = MODE_CTRL;
      chars_left_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r        <= KEY_RESET;
      line_end_r   <= LINE_END_RESET;
      mode_r       <= MODE_CTRL;
      chars_left_r <= 7'd0;
    end else begin
      if (cfg_valid && cfg_index == REG_LITERAL_KEY) begin
        key_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_LINE_END_CODE) begin
        line_end_r <= cfg_data;
      end
      if (item_adv) begin
        mode_r       <= mode_nxt;
        chars_left_r <= chars_left_nxt;
      end
    end
  end

  // an open run always owes characters, and control mode owes none
  a_mode_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_CTRL) == (chars_left_r == 7'd0))
    else $error("run mode and character count disagree");

endmodule

>>> src/tnd_res_fifo.sv
module tnd_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tnd_pkg::res_t res,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import tnd_pkg::*;

  logic [7:0]       byte_q [FIFO_DEPTH];
  logic             last_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       push_n;
  logic             pop;

  assign push_n    = push ? res.cnt : 2'd0;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  // room for a two-word item
  assign room      = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign out_byte  = byte_q[rd_ptr_r];
  assign out_last  = last_q[rd_ptr_r];
  assign count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      byte_q[wr_ptr_r] <= res.byte0;
      last_q[wr_ptr_r] <= (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      byte_q[wr_ptr_r + PTR_W'(1)] <= res.byte1;
      last_q[wr_ptr_r + PTR_W'(1)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // the two words of a packed byte are pushed together
  a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (count_r >= CNT_W'(2)))
    else $error("first of a pair queued without its partner");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !room) |-> 1'b0)
    else $error("item decoded while queue short of room");

endmodule

>>> src/text_run_nibble_decoder_top.sv
// Path: a word accepted into the input register is decoded there and is pushed
//   into the result queue once it has room for two bytes; the head drives out_*.
// Throughput: one word per cycle for runs yielding one byte each, while out_stall
//   is low; a two-character packed byte holds the single result port for both.
// Reset: rst_n synchronous, active low; clears modes, run count and queue,
//   and returns the keys to 0x33 and 0x0D.
module text_run_nibble_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  // encoded stream
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  // decoded text
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  // config writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tnd_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_fend_r;
  logic       room;
  logic       adv;
  res_t       res;

  // the held word moves into the decoder once the queue can take two bytes
  assign adv       = in_valid_r && room;
  assign in_stall  = in_valid_r && !room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_fend_r <= in_frame_end;
    end
  end

  // run state and per-byte decode
  tnd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_adv  (adv),
    .item_byte (in_byte_r),
    .item_fend (in_fend_r),
    .res       (res)
  );

  // result queue; the head is the output register
  tnd_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tnd_pkg::*;

  // packed-run character set, one entry per 4-bit code
  localparam logic [7:0] GLYPHS [16] = '{
    8'h00, 8'h20, 8'h2D, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33,
    8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h0A, 8'h00
  };

  // one decoded text word as it should leave the block
  typedef struct {
    logic [7:0] text;
    logic       tail;
  } text_word_t;

  // directed probe: stream word, frame end, and a hand-worked result where
  // one is given (typed), otherwise the decoder model supplies it
  typedef struct {
    logic [7:0] code;
    logic       fe;
    bit         typed;
    int         n;
    logic [7:0] t0;
    logic [7:0] t1;
  } probe_row_t;

  localparam int N_PROBES = 25;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte      = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index    = REG_LITERAL_KEY;
  logic [7:0] cfg_data     = 8'h00;

  // decoder model state, mirrors the block's registers
  mode_t      run_mode   = MODE_CTRL;
  logic [6:0] run_left   = 7'd0;
  logic [7:0] key_q      = KEY_RESET;
  logic [7:0] line_end_q = LINE_END_RESET;

  text_word_t  pending_text [$];
  int unsigned fault_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  probe_row_t probes [N_PROBES] = '{
    // line terminator straight after reset
    '{8'hFF, 1'b0, 1'b1, 1, 8'h0D, 8'h00},
    // zero-length literal and packed runs: nothing out, stay in control
    '{8'h00, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    // literal run of three, byte extremes through the reset key
    '{8'h03, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b1, 1, 8'h33, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 1, 8'hCC, 8'h00},
    '{8'h33, 1'b0, 1'b1, 1, 8'h00, 8'h00},
    // packed run of five; low code 0 cuts it short on the second word
    '{8'h85, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'h12, 1'b0, 1'b1, 2, 8'h20, 8'h2D},
    '{8'hE0, 1'b0, 1'b1, 1, 8'h0A, 8'h00},
    // high code 0 still goes out as a 0x00 character
    '{8'h84, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'h0F, 1'b0, 1'b1, 1, 8'h00, 8'h00},
    // odd count: last word gives the high character only
    '{8'h83, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'hDE, 1'b0, 1'b1, 2, 8'h39, 8'h0A},
    '{8'h45, 1'b0, 1'b1, 1, 8'h30, 8'h00},
    // run opened on a frame end is dropped at once
    '{8'h05, 1'b1, 1'b1, 0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 1, 8'h0D, 8'h00},
    // frame end on a word that gives two characters
    '{8'h82, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'h77, 1'b1, 1'b1, 2, 8'h33, 8'h33},
    '{8'hFF, 1'b1, 1'b1, 1, 8'h0D, 8'h00},
    // longest literal run, cut by a frame end
    '{8'h7F, 1'b0, 1'b1, 0, 8'h00, 8'h00},
    '{8'hAA, 1'b1, 1'b1, 1, 8'h99, 8'h00},
    // longest packed run, cut by a frame end; model checked
    '{8'hFE, 1'b0, 1'b0, 0, 8'h00, 8'h00},
    '{8'h9C, 1'b0, 1'b0, 0, 8'h00, 8'h00},
    '{8'hC1, 1'b1, 1'b0, 0, 8'h00, 8'h00}
  };

  // settings per random segment, extremes first
  logic [7:0] key_plan  [6] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80};
  logic [7:0] term_plan [6] = '{8'hFF, 8'h00, 8'h0A, 8'h0D, 8'h7F, 8'h80};

  text_run_nibble_decoder_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decode one accepted stream word into 0..2 text characters and advance
  // the model state. Frame end wins over whatever the word did to the run.
  function automatic void decode_word(input logic [7:0] b, input logic fe,
                                      output int n, output logic [7:0] r0,
                                      output logic [7:0] r1);
    logic [7:0] hi;
    logic [7:0] lo;
    n  = 0;
    r0 = 8'h00;
    r1 = 8'h00;
    hi = GLYPHS[b[7:4]];
    lo = GLYPHS[b[3:0]];
    case (run_mode)
      MODE_LIT: begin
        r0 = b ^ key_q;
        n  = 1;
        if (run_left != 7'd0) run_left = run_left - 7'd1;
        if (run_left == 7'd0) run_mode = MODE_CTRL;
      end
      MODE_PACK: begin
        r0 = hi;
        n  = 1;
        // low character only while two or more are owed and it is not 0x00
        if (run_left >= 7'd2 && lo != 8'h00) begin
          r1       = lo;
          n        = 2;
          run_left = run_left - 7'd2;
        end else begin
          run_left = 7'd0;
        end
        if (run_left == 7'd0) run_mode = MODE_CTRL;
      end
      default: begin
        // control state; unused mode code lands here too
        if (b == CTRL_LINE_END) begin
          r0       = line_end_q;
          n        = 1;
          run_left = 7'd0;
          run_mode = MODE_CTRL;
        end else begin
          run_left = b[6:0];
          if (run_left == 7'd0) run_mode = MODE_CTRL;
          else run_mode = b[7] ? MODE_PACK : MODE_LIT;
        end
      end
    endcase
    if (fe) begin
      run_mode = MODE_CTRL;
      run_left = 7'd0;
    end
  endfunction

  // Offer one stream word, hold it until taken, then queue what it decodes
  // to. A typed probe replaces the model's characters with hand-worked ones.
  task automatic send_word(input logic [7:0] b, input logic fe,
                           input bit typed = 1'b0, input int tn = 0,
                           input logic [7:0] t0 = 8'h00,
                           input logic [7:0] t1 = 8'h00);
    int         n;
    logic [7:0] r0;
    logic [7:0] r1;
    text_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (in_stall);
    decode_word(b, fe, n, r0, r1);
    if (typed) begin
      n  = tn;
      r0 = t0;
      r1 = t1;
    end
    for (int k = 0; k < n; k++) begin
      w.text = (k == 0) ? r0 : r1;
      w.tail = (k == n - 1);
      pending_text = {pending_text, w};
    end
  endtask

  // Let the block go quiet: every queued character out, then a further idle wait,
  // since a run-opening word yields nothing yet may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers in one burst; valid stays up across the two writes.
  task automatic program_keys(input logic [7:0] key, input logic [7:0] term);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LITERAL_KEY;
    cfg_data  <= key;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_LINE_END_CODE;
    cfg_data  <= term;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    key_q      = key;
    line_end_q = term;
  endtask

  // Random encoded text: mostly whole runs with random content, some line
  // ends and empty runs, a sprinkling of stray words, truncated runs and
  // frame ends landing mid-run.
  task automatic make_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned nwords;
    int unsigned r;
    logic        packed_run;
    logic        fe;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_word(8'($urandom_range(255)), $urandom_range(9) == 0);
        sent++;
      end else if (r < 20) begin
        send_word(CTRL_LINE_END, $urandom_range(19) == 0);
        sent++;
      end else if (r < 24) begin
        send_word({$urandom_range(1) == 1, 7'd0}, $urandom_range(9) == 0);
        sent++;
      end else begin
        packed_run = 1'($urandom_range(1));
        r = $urandom_range(99);
        // mostly short runs; 0xFF is the line end, so packed tops out at 126
        if (r < 85) len = $urandom_range(8, 1);
        else if (r < 95) len = $urandom_range(40, 9);
        else len = $urandom_range(packed_run ? 126 : 127, 41);
        send_word({packed_run, len[6:0]}, 1'b0);
        sent++;
        nwords = packed_run ? (len + 1) / 2 : len;
        if ($urandom_range(19) == 0) nwords = $urandom_range(nwords);
        for (int unsigned i = 0; i < nwords; i++) begin
          b = 8'($urandom_range(255));
          // keep low codes off 0 and F most of the time so runs finish whole
          if (packed_run && $urandom_range(9) != 0) b[3:0] = 4'($urandom_range(14, 1));
          fe = (i == nwords - 1) ? ($urandom_range(9) < 3) : ($urandom_range(49) == 0);
          send_word(b, fe);
          sent++;
          if (fe) break;
        end
      end
    end
  endtask

  // Receiver: stall at the current idling rate, never during reset.
  always @(posedge clk) begin
    out_stall <= rst_n ? ($urandom_range(99) < recv_idle_pct) : 1'b0;
  end

  // Scoreboard: every taken text word against the oldest one owed.
  always @(posedge clk) begin
    text_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        $error("unexpected word: out_byte %h out_last %b", out_byte, out_last);
        fault_cnt++;
      end else begin
        want = pending_text.pop_front();
        if (out_byte !== want.text) begin
          $error("out_byte: expected %h, got %h", want.text, out_byte);
          fault_cnt++;
        end
        if (out_last !== want.tail) begin
          $error("out_last: expected %b, got %b", want.tail, out_last);
          fault_cnt++;
        end
      end
    end
  end

  // Main sequence: reset, directed probes on reset keys, then three idling
  // regimes of two segments each, keys reprogrammed while quiet.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 87;
    for (int p = 0; p < N_PROBES; p++) begin
      send_word(probes[p].code, probes[p].fe, probes[p].typed, probes[p].n,
                probes[p].t0, probes[p].t1);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 22 : 0;
      for (int s = 0; s < 2; s++) begin
        // sender holds off until every owed character has come back
        drain();
        program_keys(key_plan[2 * ph + s], term_plan[2 * ph + s]);
        make_traffic(312);
      end
    end

    drain();
    if (pending_text.size() != 0) begin
      $error("%0d text words never arrived", pending_text.size());
      fault_cnt++;
    end
    if (fault_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: ends a hung run with an error, well beyond the slowest honest run (1900
  // words, two characters each, behind an 87% receiver stall).
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
